>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of i_clk outside reset
`define CHK_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// Next-cycle implication
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

>>> rtl/core/slpq_pkg.sv
`timescale 1ns / 1ps
package slpq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PTR_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int ENT_W    = 2 * DATA_W;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [PTR_W-1:0] t_ptr;

    localparam t_ptr NIL = t_ptr'(CAPACITY);

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_TOP  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_A,
        S_PUSH_B,
        S_PUSH_C,
        S_WALK,
        S_LINK,
        S_POP_A,
        S_POP_B
    } t_state;

    typedef struct packed {
        logic             ent_we;
        t_idx             ent_waddr;
        logic [ENT_W-1:0] ent_wdata;
        t_idx             ent_raddr;
        logic             lnk_we;
        t_idx             lnk_waddr;
        t_ptr             lnk_wdata;
        t_idx             lnk_raddr;
    } t_mem_req;

    // a ranks with or ahead of b
    function automatic logic ranks_first(logic signed [DATA_W-1:0] a,
                                         logic signed [DATA_W-1:0] b,
                                         logic mode);
        return mode ? (a >= b) : (a <= b);
    endfunction

    function automatic logic is_node(t_ptr p);
        return p < NIL;
    endfunction

endpackage

>>> rtl/core/slpq_store.sv
`timescale 1ns / 1ps
module slpq_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  slpq_pkg::t_mem_req           i_req,
    output logic [slpq_pkg::ENT_W-1:0]   o_ent_rdata,
    output slpq_pkg::t_ptr               o_lnk_rdata
);

    logic [slpq_pkg::ENT_W-1:0] r_ent_mem [slpq_pkg::CAPACITY];
    slpq_pkg::t_ptr             r_lnk_mem [slpq_pkg::CAPACITY];
    logic [slpq_pkg::CAPACITY-1:0] r_lnk_vld;

    logic [slpq_pkg::ENT_W-1:0] r_ent_q;
    slpq_pkg::t_ptr             r_lnk_q;
    logic                       r_lnk_hit;
    slpq_pkg::t_idx             r_lnk_ra;

    always_ff @(posedge i_clk) begin
        if (i_req.ent_we) begin
            r_ent_mem[i_req.ent_waddr] <= i_req.ent_wdata;
        end
        r_ent_q <= r_ent_mem[i_req.ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.lnk_we) begin
            r_lnk_mem[i_req.lnk_waddr] <= i_req.lnk_wdata;
        end
        r_lnk_q  <= r_lnk_mem[i_req.lnk_raddr];
        r_lnk_ra <= i_req.lnk_raddr;
    end

    // untouched link entries read as the reset free chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lnk_vld <= '0;
            r_lnk_hit <= 1'b0;
        end else begin
            if (i_req.lnk_we) begin
                r_lnk_vld[i_req.lnk_waddr] <= 1'b1;
            end
            r_lnk_hit <= r_lnk_vld[i_req.lnk_raddr];
        end
    end

    assign o_ent_rdata = r_ent_q;
    assign o_lnk_rdata = r_lnk_hit ? r_lnk_q
                                   : slpq_pkg::t_ptr'(r_lnk_ra) + slpq_pkg::t_ptr'(1);

endmodule

>>> rtl/core/sorted_list_priority_queue.sv
`timescale 1ns / 1ps
// Sequencing: refused push, pop/top on empty queue, unused codes answer from S_IDLE; pop/top
//   use S_POP_A/B; push S_PUSH_A/B, then, if not ahead of the head, S_PUSH_C, S_WALK, S_LINK.
// Throughput: one word at a time; a push walks the link memory one node per read.
//   Results cannot be stalled.
// Reset: synchronous, active low; empty queue, free chain through all nodes, ascending order.
//   No clearing pass: per-entry valid bits stand in for the initial link chain.
module sorted_list_priority_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_action,
    input  logic [slpq_pkg::DATA_W-1:0]         i_elem_value,
    input  logic signed [slpq_pkg::DATA_W-1:0]  i_priority_req,
    output logic                                o_valid,
    output logic [slpq_pkg::DATA_W-1:0]         o_out_value,
    output logic signed [slpq_pkg::DATA_W-1:0]  o_out_priority,
    output logic [1:0]                          o_status,
    output logic                                o_is_empty
);

    slpq_pkg::t_state r_state, n_state;
    logic             r_order;
    slpq_pkg::t_ptr   r_head, n_head;
    slpq_pkg::t_ptr   r_free, n_free;
    slpq_pkg::t_ptr   r_count, n_count;
    slpq_pkg::t_ptr   r_prev, n_prev;
    slpq_pkg::t_ptr   r_cur, n_cur;
    slpq_pkg::t_ptr   r_steps, n_steps;
    slpq_pkg::t_idx   r_node, n_node;
    slpq_pkg::t_action r_action, n_action;
    logic [slpq_pkg::DATA_W-1:0]        r_value, n_value;
    logic signed [slpq_pkg::DATA_W-1:0] r_prio, n_prio;

    logic                               r_valid, n_valid;
    logic [slpq_pkg::DATA_W-1:0]        r_out_value, n_out_value;
    logic signed [slpq_pkg::DATA_W-1:0] r_out_prio, n_out_prio;
    slpq_pkg::t_status                  r_status, n_status;
    logic                               r_empty, n_empty;

    slpq_pkg::t_mem_req               mem_req;
    logic [slpq_pkg::ENT_W-1:0]       ent_rd;
    slpq_pkg::t_ptr                   lnk_rd;
    logic signed [slpq_pkg::DATA_W-1:0] ent_prio;
    logic                             q_full, q_empty, head_wins, walk_go;
    slpq_pkg::t_action                in_act;

    slpq_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (mem_req),
        .o_ent_rdata (ent_rd),
        .o_lnk_rdata (lnk_rd)
    );

    assign in_act    = slpq_pkg::t_action'(i_action);
    assign ent_prio  = $signed(ent_rd[slpq_pkg::DATA_W-1:0]);
    assign q_full    = (r_count >= slpq_pkg::NIL) || !slpq_pkg::is_node(r_free);
    assign q_empty   = !slpq_pkg::is_node(r_head) || (r_count == '0);
    assign head_wins = !slpq_pkg::is_node(r_head)
                       || slpq_pkg::ranks_first(r_prio, ent_prio, r_order);
    assign walk_go   = slpq_pkg::is_node(r_cur) && (r_steps < r_count)
                       && slpq_pkg::ranks_first(ent_prio, r_prio, r_order);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slpq_pkg::S_IDLE: begin
                if (start) begin
                    unique case (in_act)
                        slpq_pkg::ACT_PUSH: n_state = q_full ? slpq_pkg::S_IDLE
                                                             : slpq_pkg::S_PUSH_A;
                        slpq_pkg::ACT_POP,
                        slpq_pkg::ACT_TOP:  n_state = q_empty ? slpq_pkg::S_IDLE
                                                              : slpq_pkg::S_POP_A;
                        default:            n_state = slpq_pkg::S_IDLE;
                    endcase
                end
            end
            slpq_pkg::S_PUSH_A: n_state = slpq_pkg::S_PUSH_B;
            slpq_pkg::S_PUSH_B: n_state = head_wins ? slpq_pkg::S_IDLE : slpq_pkg::S_PUSH_C;
            slpq_pkg::S_PUSH_C: n_state = slpq_pkg::S_WALK;
            slpq_pkg::S_WALK:   n_state = walk_go ? slpq_pkg::S_WALK : slpq_pkg::S_LINK;
            slpq_pkg::S_LINK:   n_state = slpq_pkg::S_IDLE;
            slpq_pkg::S_POP_A:  n_state = slpq_pkg::S_POP_B;
            slpq_pkg::S_POP_B:  n_state = slpq_pkg::S_IDLE;
            default:            n_state = slpq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_free      = r_free;
        n_count     = r_count;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_node      = r_node;
        n_action    = r_action;
        n_value     = r_value;
        n_prio      = r_prio;
        n_valid     = 1'b0;
        n_out_value = '0;
        n_out_prio  = '0;
        n_status    = slpq_pkg::ST_OK;
        n_empty     = (r_count == '0);

        mem_req           = '0;
        mem_req.ent_waddr = r_node;
        mem_req.ent_wdata = {r_value, r_prio};
        mem_req.ent_raddr = r_head[slpq_pkg::IDX_W-1:0];
        mem_req.lnk_raddr = r_head[slpq_pkg::IDX_W-1:0];
        mem_req.lnk_waddr = r_node;

        unique case (r_state)
            slpq_pkg::S_IDLE: begin
                if (start) begin
                    n_action = in_act;
                    n_value  = i_elem_value;
                    n_prio   = i_priority_req;
                    n_node   = r_free[slpq_pkg::IDX_W-1:0];
                    unique case (in_act)
                        slpq_pkg::ACT_PUSH: begin
                            if (q_full) begin
                                n_valid  = 1'b1;
                                n_status = slpq_pkg::ST_FULL;
                            end
                        end
                        slpq_pkg::ACT_POP,
                        slpq_pkg::ACT_TOP: begin
                            if (q_empty) begin
                                n_valid  = 1'b1;
                                n_status = slpq_pkg::ST_EMPTY;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            slpq_pkg::S_PUSH_A: begin
                mem_req.ent_we    = 1'b1;
                mem_req.lnk_raddr = r_node;
            end
            slpq_pkg::S_PUSH_B: begin
                n_free = lnk_rd;
                if (head_wins) begin
                    mem_req.lnk_we    = 1'b1;
                    mem_req.lnk_wdata = slpq_pkg::is_node(r_head) ? r_head : slpq_pkg::NIL;
                    n_head  = slpq_pkg::t_ptr'(r_node);
                    n_count = r_count + slpq_pkg::t_ptr'(1);
                    n_valid = 1'b1;
                    n_empty = 1'b0;
                end else begin
                    n_prev = r_head;
                end
            end
            slpq_pkg::S_PUSH_C: begin
                n_cur             = lnk_rd;
                n_steps           = '0;
                mem_req.ent_raddr = lnk_rd[slpq_pkg::IDX_W-1:0];
                mem_req.lnk_raddr = lnk_rd[slpq_pkg::IDX_W-1:0];
            end
            slpq_pkg::S_WALK: begin
                if (walk_go) begin
                    n_prev            = r_cur;
                    n_cur             = lnk_rd;
                    n_steps           = r_steps + slpq_pkg::t_ptr'(1);
                    mem_req.ent_raddr = lnk_rd[slpq_pkg::IDX_W-1:0];
                    mem_req.lnk_raddr = lnk_rd[slpq_pkg::IDX_W-1:0];
                end else begin
                    mem_req.lnk_we    = 1'b1;
                    mem_req.lnk_wdata = slpq_pkg::is_node(r_cur) ? r_cur : slpq_pkg::NIL;
                end
            end
            slpq_pkg::S_LINK: begin
                mem_req.lnk_we    = 1'b1;
                mem_req.lnk_waddr = r_prev[slpq_pkg::IDX_W-1:0];
                mem_req.lnk_wdata = slpq_pkg::t_ptr'(r_node);
                n_count = r_count + slpq_pkg::t_ptr'(1);
                n_valid = 1'b1;
                n_empty = 1'b0;
            end
            slpq_pkg::S_POP_A: begin
            end
            slpq_pkg::S_POP_B: begin
                n_valid     = 1'b1;
                n_out_value = ent_rd[slpq_pkg::ENT_W-1:slpq_pkg::DATA_W];
                n_out_prio  = ent_prio;
                if (r_action == slpq_pkg::ACT_POP) begin
                    n_count           = r_count - slpq_pkg::t_ptr'(1);
                    n_empty           = (n_count == '0);
                    n_head            = (n_count == '0) || !slpq_pkg::is_node(lnk_rd)
                                        ? slpq_pkg::NIL : lnk_rd;
                    n_free            = r_head;
                    mem_req.lnk_we    = 1'b1;
                    mem_req.lnk_waddr = r_head[slpq_pkg::IDX_W-1:0];
                    mem_req.lnk_wdata = r_free;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slpq_pkg::S_IDLE;
            r_order <= 1'b0;
            r_head  <= slpq_pkg::NIL;
            r_free  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_count <= n_count;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev      <= n_prev;
        r_cur       <= n_cur;
        r_steps     <= n_steps;
        r_node      <= n_node;
        r_action    <= n_action;
        r_value     <= n_value;
        r_prio      <= n_prio;
        r_out_value <= n_out_value;
        r_out_prio  <= n_out_prio;
        r_status    <= n_status;
        r_empty     <= n_empty;
    end

    assign busy           = (r_state != slpq_pkg::S_IDLE);
    assign o_valid        = r_valid;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_prio;
    assign o_status       = r_status;
    assign o_is_empty     = r_empty;

endmodule

>>> rtl/core/slpq_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slpq_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_valid,
    input logic [slpq_pkg::DATA_W-1:0]         o_out_value,
    input logic signed [slpq_pkg::DATA_W-1:0]  o_out_priority,
    input logic [1:0]                          o_status,
    input logic                                o_is_empty
);

    // an accepted word is either being worked on or answered next cycle
    `CHK_NEXT(a_accept_progress, start && !busy, busy || o_valid)

    // an empty queue answers with zero fields
    `CHK_NOW(a_empty_zero, o_valid && (o_status == slpq_pkg::ST_EMPTY),
             (o_out_value == '0) && (o_out_priority == '0))

    // a refused push leaves a full queue behind, so the empty flag stays low
    `CHK_NOW(a_full_kept, o_valid && (o_status == slpq_pkg::ST_FULL), !o_is_empty)

    // results never carry the spare status code
    `CHK_NOW(a_status_code, o_valid, o_status != 2'd3)

endmodule

bind sorted_list_priority_queue slpq_chk u_slpq_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_out_value    (o_out_value),
    .o_out_priority (o_out_priority),
    .o_status       (o_status),
    .o_is_empty     (o_is_empty)
);

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct {
        logic [slpq_pkg::DATA_W-1:0]        value;
        logic signed [slpq_pkg::DATA_W-1:0] prio;
        slpq_pkg::t_status                  status;
        logic                               empty;
    } t_head_word;

    // shadow copy of the sorted list, used to work out every answer
    class pq_shadow;
        logic [slpq_pkg::DATA_W-1:0]        node_value [slpq_pkg::CAPACITY];
        logic signed [slpq_pkg::DATA_W-1:0] node_prio  [slpq_pkg::CAPACITY];
        int                                 node_next  [slpq_pkg::CAPACITY];
        int                                 head_node;
        int                                 free_node;
        int                                 fill;
        bit                                 largest_first;
        t_head_word                         due_words[$];
        int                                 errors;

        function new();
            for (int i = 0; i < slpq_pkg::CAPACITY; i++) begin
                node_next[i]  = i + 1;
                node_value[i] = '0;
                node_prio[i]  = '0;
            end
            head_node     = slpq_pkg::CAPACITY;
            free_node     = 0;
            fill          = 0;
            largest_first = 1'b0;
            errors        = 0;
        endfunction

        function bit serves_first(logic signed [slpq_pkg::DATA_W-1:0] a,
                                  logic signed [slpq_pkg::DATA_W-1:0] b);
            return largest_first ? (a >= b) : (a <= b);
        endfunction

        function void note_word(slpq_pkg::t_action act, logic [slpq_pkg::DATA_W-1:0] v,
                                logic signed [slpq_pkg::DATA_W-1:0] p);
            t_head_word w;
            int node;
            int prev;
            int cur;
            int steps;
            w.value  = '0;
            w.prio   = '0;
            w.status = slpq_pkg::ST_OK;
            case (act)
                slpq_pkg::ACT_PUSH: begin
                    if (fill >= slpq_pkg::CAPACITY || free_node >= slpq_pkg::CAPACITY) begin
                        w.status = slpq_pkg::ST_FULL;
                    end else begin
                        node = free_node;
                        free_node = node_next[node];
                        node_value[node] = v;
                        node_prio[node]  = p;
                        if (head_node >= slpq_pkg::CAPACITY ||
                            serves_first(p, node_prio[head_node])) begin
                            node_next[node] = head_node;
                            head_node = node;
                        end else begin
                            prev  = head_node;
                            cur   = node_next[prev];
                            steps = 0;
                            while (cur < slpq_pkg::CAPACITY && steps < fill &&
                                   serves_first(node_prio[cur], p)) begin
                                prev = cur;
                                cur  = node_next[cur];
                                steps++;
                            end
                            node_next[node] = (cur < slpq_pkg::CAPACITY) ? cur
                                                                         : slpq_pkg::CAPACITY;
                            node_next[prev] = node;
                        end
                        fill++;
                    end
                end
                slpq_pkg::ACT_POP, slpq_pkg::ACT_TOP: begin
                    if (head_node >= slpq_pkg::CAPACITY || fill == 0) begin
                        w.status = slpq_pkg::ST_EMPTY;
                    end else begin
                        node    = head_node;
                        w.value = node_value[node];
                        w.prio  = node_prio[node];
                        if (act == slpq_pkg::ACT_POP) begin
                            head_node = (node_next[node] < slpq_pkg::CAPACITY)
                                        ? node_next[node] : slpq_pkg::CAPACITY;
                            node_next[node] = free_node;
                            free_node = node;
                            fill--;
                            if (fill == 0)
                                head_node = slpq_pkg::CAPACITY;
                        end
                    end
                end
                default: ;
            endcase
            w.empty = (fill == 0);
            due_words.push_back(w);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_word(logic [slpq_pkg::DATA_W-1:0] v, logic signed [slpq_pkg::DATA_W-1:0] p,
                        logic [1:0] st, logic e);
            t_head_word w;
            if (due_words.size() == 0) begin
                report("result word with none outstanding");
            end else begin
                w = due_words.pop_front();
                if (v !== w.value)
                    report($sformatf("value %h, expected %h", v, w.value));
                if (p !== w.prio)
                    report($sformatf("priority %0d, expected %0d", p, w.prio));
                if (st !== w.status)
                    report($sformatf("status %0d, expected %0d", st, w.status));
                if (e !== w.empty)
                    report($sformatf("empty flag %b, expected %b", e, w.empty));
            end
        endtask
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic                               i_cfg_wdata = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic [1:0]                         i_action = slpq_pkg::ACT_NONE;
    logic [slpq_pkg::DATA_W-1:0]        i_elem_value = '0;
    logic signed [slpq_pkg::DATA_W-1:0] i_priority_req = '0;
    logic                               o_valid;
    logic [slpq_pkg::DATA_W-1:0]        o_out_value;
    logic signed [slpq_pkg::DATA_W-1:0] o_out_priority;
    logic [1:0]                         o_status;
    logic                               o_is_empty;

    pq_shadow sb = new();
    bit       gaps_on = 1'b1;
    int       cycles = 0;

    sorted_list_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_elem_value   (i_elem_value),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_status       (o_status),
        .o_is_empty     (o_is_empty)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_word(o_out_value, o_out_priority, o_status, o_is_empty);
    end

    task automatic send_word(slpq_pkg::t_action act, logic [slpq_pkg::DATA_W-1:0] v,
                             logic signed [slpq_pkg::DATA_W-1:0] p);
        i_action       <= act;
        i_elem_value   <= v;
        i_priority_req <= p;
        start          <= 1'b1;
        do @(posedge i_clk); while (!(start && !busy));
        sb.note_word(act, v, p);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // hold off until every outstanding word has come back
    task automatic drain();
        start <= 1'b0;
        while (sb.due_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_order(bit largest);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= largest;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.largest_first = largest;
    endtask

    function automatic logic signed [slpq_pkg::DATA_W-1:0] pick_prio(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 8)) - 4;
            default: begin
                case ($urandom_range(0, 6))
                    0: return 32'sh8000_0000;
                    1: return 32'sh8000_0001;
                    2: return -1;
                    3: return 0;
                    4: return 1;
                    5: return 32'sh7FFF_FFFE;
                    default: return 32'sh7FFF_FFFF;
                endcase
            end
        endcase
    endfunction

    task automatic run_mix(int n, int push_pct, int kind);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                send_word(slpq_pkg::ACT_PUSH, $urandom, pick_prio(kind));
            else if (r < push_pct + (100 - push_pct) * 2 / 3)
                send_word(slpq_pkg::ACT_POP, $urandom, $urandom);
            else if (r < 98)
                send_word(slpq_pkg::ACT_TOP, $urandom, $urandom);
            else
                send_word(slpq_pkg::ACT_NONE, $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, unused code, ties at and behind the head, extremes
        send_word(slpq_pkg::ACT_POP,  32'h0, 0);
        send_word(slpq_pkg::ACT_TOP,  32'hFFFF_FFFF, -1);
        send_word(slpq_pkg::ACT_NONE, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        send_word(slpq_pkg::ACT_PUSH, 32'h0000_0005, 0);
        send_word(slpq_pkg::ACT_PUSH, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        send_word(slpq_pkg::ACT_PUSH, 32'h0000_0000, 32'sh8000_0000);
        send_word(slpq_pkg::ACT_PUSH, 32'h0000_000A, 0);
        send_word(slpq_pkg::ACT_PUSH, 32'h0000_000B, 32'sh8000_0000);
        send_word(slpq_pkg::ACT_PUSH, 32'hA5A5_5A5A, -1);
        send_word(slpq_pkg::ACT_TOP,  32'h0, 0);
        repeat (6) send_word(slpq_pkg::ACT_POP, 32'h0, 0);
        send_word(slpq_pkg::ACT_POP,  32'h0, 0);
        send_word(slpq_pkg::ACT_TOP,  32'h0, 0);
        set_order(1'b1);
        send_word(slpq_pkg::ACT_PUSH, 32'h1111_1111, 0);
        send_word(slpq_pkg::ACT_PUSH, 32'h2222_2222, 32'sh8000_0000);
        send_word(slpq_pkg::ACT_PUSH, 32'h3333_3333, 32'sh7FFF_FFFF);
        send_word(slpq_pkg::ACT_PUSH, 32'h4444_4444, 0);
        send_word(slpq_pkg::ACT_PUSH, 32'h5555_5555, 32'sh7FFF_FFFF);
        repeat (5) send_word(slpq_pkg::ACT_POP, 32'h0, 0);
        set_order(1'b0);

        for (int ph = 0; ph < 10; ph++) begin
            if (ph < 2)
                set_order(ph[0]);
            else
                set_order(1'($urandom_range(0, 1)));
            gaps_on = (ph < 8);
            case (ph % 3)
                0: run_mix(175, 80, $urandom_range(0, 2));
                1: begin
                    run_mix(90, 50, $urandom_range(0, 2));
                    drain();
                    run_mix(85, 50, $urandom_range(0, 2));
                end
                default: run_mix(175, 20, $urandom_range(0, 2));
            endcase
        end

        start <= 1'b0;
        while (sb.due_words.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
